// File: hw/rtl/srq_pkg.sv
// ----------------------------------------------------------------------------
// srq_pkg: shared types and constants for the sorted ready queue
// Record layout, operation and status codes, and the control bundle that the
// top level broadcasts to every cell of the queue.
// ----------------------------------------------------------------------------
package srq_pkg;

  localparam int unsigned SrqDepth = 10;

  typedef enum logic [1:0] {
    OP_PUSH     = 2'd0,
    OP_POP_TAIL = 2'd1,
    OP_POP_HEAD = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] burst;
    logic [7:0]  prio;
    logic [15:0] arrival;
  } rec_t;

  // Broadcast to all cells in the cycle a transaction is taken.
  typedef struct packed {
    logic push_en;  // push that fits
    logic head_en;  // pop head on a non-empty queue
    logic sorted;   // insert by priority
    rec_t rec;      // record being pushed
  } cell_ctrl_t;

endpackage

// File: hw/rtl/srq_cell.sv
// ----------------------------------------------------------------------------
// srq_cell: one slot of the queue
// Holds one record. Shifts toward the tail on an insert below it, toward the
// head on a head pop, and passes the insert mark and the tail record along.
// ----------------------------------------------------------------------------
module srq_cell
  import srq_pkg::*;
#(
  parameter int unsigned Idx  = 0,
  parameter int unsigned CntW = 4
) (
  input  logic            clk_i,
  input  cell_ctrl_t      ctrl_i,
  input  logic [CntW-1:0] cnt_i,
  input  rec_t            lo_rec_i,
  input  logic            lo_mark_i,
  input  rec_t            hi_rec_i,
  input  logic            hi_mark_i,
  input  rec_t            hi_tail_i,
  output rec_t            rec_o,
  output logic            mark_o,
  output rec_t            tail_o
);

  rec_t rec_q, rec_d;
  logic occ;
  logic gt;

  assign occ = CntW'(Idx) < cnt_i;
  assign gt  = occ && (rec_q.prio > ctrl_i.rec.prio);

  // Mark: this cell and all occupied cells above it move up on an insert.
  assign mark_o = !occ || (ctrl_i.sorted && gt && hi_mark_i);

  assign tail_o = (CntW'(Idx + 1) == cnt_i) ? rec_q : hi_tail_i;
  assign rec_o  = rec_q;

  always_comb begin
    rec_d = rec_q;
    if (ctrl_i.push_en && mark_o) begin
      rec_d = lo_mark_i ? lo_rec_i : ctrl_i.rec;
    end else if (ctrl_i.head_en) begin
      rec_d = hi_rec_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

endmodule

// File: hw/rtl/sorted_ready_queue.sv
// ----------------------------------------------------------------------------
// sorted_ready_queue: bounded ready queue of process records
// A row of Depth cells; push inserts by priority or at the tail, pops take
// the tail or the head. One result per transaction.
// ----------------------------------------------------------------------------
//  channel   | signals                                   | dir
//  ----------+-------------------------------------------+-----
//  in        | in_valid_i/in_ready_o, op_i, in_*_i       | in
//  out       | out_valid_o/out_ready_i, status_o, out_*_o| out
//  config    | sorted_mode_we_i, sorted_mode_i           | in
//
//  One transaction per cycle: every cell compares and shifts in the same
//  cycle, the insert mark ripples once along the row of cells.
//  The result sits in an output register; a new transaction is taken while
//  the result is being taken. Only out_ready_i low with a held result stalls.
//  Reset clears the count, the mode and the output valid; cells hold no reset.
// ----------------------------------------------------------------------------
module sorted_ready_queue
  import srq_pkg::*;
#(
  parameter int unsigned Depth = SrqDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        sorted_mode_we_i,
  input  logic        sorted_mode_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] in_id_i,
  input  logic [15:0] in_burst_i,
  input  logic [7:0]  in_priority_i,
  input  logic [15:0] in_arrival_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [15:0] out_id_o,
  output logic [15:0] out_burst_o,
  output logic [7:0]  out_priority_o,
  output logic [15:0] out_arrival_o,
  output logic [3:0]  occupancy_o
);

  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            sorted_q;
  logic            out_valid_q;
  status_e         status_q, status_d;
  rec_t            res_q, res_d;
  logic [3:0]      occ_q;

  logic       take;
  logic       full, empty;
  cell_ctrl_t ctrl;
  rec_t       new_rec;

  rec_t rec_w  [Depth];
  logic mark_w [Depth];
  rec_t tail_w [Depth];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;
  assign full       = cnt_q == CntW'(Depth);
  assign empty      = cnt_q == '0;

  assign new_rec = '{id: in_id_i, burst: in_burst_i, prio: in_priority_i,
                     arrival: in_arrival_i};

  always_comb begin
    ctrl         = '0;
    ctrl.sorted  = sorted_q;
    ctrl.rec     = new_rec;
    cnt_d        = cnt_q;
    status_d     = ST_OK;
    res_d        = '0;
    case (op_i)
      OP_PUSH: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ctrl.push_en = take;
          cnt_d        = cnt_q + CntW'(1);
        end
      end
      OP_POP_TAIL: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          res_d = tail_w[0];
          cnt_d = cnt_q - CntW'(1);
        end
      end
      OP_POP_HEAD: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          res_d        = rec_w[0];
          ctrl.head_en = take;
          cnt_d        = cnt_q - CntW'(1);
        end
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    rec_t lo_rec, hi_rec, hi_tail;
    logic lo_mark, hi_mark;

    if (i == 0) begin : g_head
      assign lo_rec  = new_rec;
      assign lo_mark = 1'b0;
    end else begin : g_mid_lo
      assign lo_rec  = rec_w[i-1];
      assign lo_mark = mark_w[i-1];
    end

    if (i == Depth - 1) begin : g_tail
      assign hi_rec  = rec_w[i];
      assign hi_mark = 1'b1;
      assign hi_tail = rec_w[i];
    end else begin : g_mid_hi
      assign hi_rec  = rec_w[i+1];
      assign hi_mark = mark_w[i+1];
      assign hi_tail = tail_w[i+1];
    end

    srq_cell #(
      .Idx  (i),
      .CntW (CntW)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .cnt_i     (cnt_q),
      .lo_rec_i  (lo_rec),
      .lo_mark_i (lo_mark),
      .hi_rec_i  (hi_rec),
      .hi_mark_i (hi_mark),
      .hi_tail_i (hi_tail),
      .rec_o     (rec_w[i]),
      .mark_o    (mark_w[i]),
      .tail_o    (tail_w[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      sorted_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (sorted_mode_we_i) begin
        sorted_q <= sorted_mode_i;
      end
      if (take) begin
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      status_q <= status_d;
      res_q    <= res_d;
      // occupancy wraps modulo 16 for deep queues
      occ_q    <= 4'(cnt_d);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign out_id_o       = res_q.id;
  assign out_burst_o    = res_q.burst;
  assign out_priority_o = res_q.prio;
  assign out_arrival_o  = res_q.arrival;
  assign occupancy_o    = occ_q;

endmodule

// File: tb/sv/sorted_ready_queue_tb.sv
// ----------------------------------------------------------------------------
// sorted_ready_queue_tb: self-checking testbench for the sorted ready queue
// Drives push, pop-tail, pop-head and unused op codes through the valid/ready
// input channel. Both modes are covered, including sorted inserts into a queue
// filled in FIFO order. A scoreboard class keeps its own copy of the queue and
// checks every result against it. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module sorted_ready_queue_tb;
  import srq_pkg::*;

  localparam logic [1:0]  OpIgnored  = 2'd3;  // unused op code, queue untouched
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseItems = 240;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] burst;
    logic [7:0]  prio;
    logic [15:0] arrival;
  } proc_rec_t;

  typedef struct packed {
    logic [1:0] status;
    proc_rec_t  rec;
    logic [3:0] occupancy;
  } queue_result_t;

  class ready_queue_model;
    proc_rec_t     entries[$];          // index 0 is the head
    bit            sorted;
    queue_result_t pending_results[$];
    int unsigned   error_count;

    function void note_transaction(logic [1:0] op, proc_rec_t rec);
      queue_result_t want;
      int unsigned   pos;
      want = '0;
      case (op)
        OP_PUSH: begin
          if (entries.size() >= SrqDepth) begin
            want.status = ST_FULL;
          end else begin
            pos = entries.size();
            // walk back from the tail only while the entry sorts after us
            if (sorted) begin
              while (pos > 0 && entries[pos-1].prio > rec.prio) pos--;
            end
            entries.insert(pos, rec);
          end
        end
        OP_POP_TAIL: begin
          if (entries.size() == 0) want.status = ST_EMPTY;
          else begin
            want.rec = entries[entries.size() - 1];
            entries.delete(entries.size() - 1);
          end
        end
        OP_POP_HEAD: begin
          if (entries.size() == 0) want.status = ST_EMPTY;
          else want.rec = entries.pop_front();
        end
        default: ;
      endcase
      want.occupancy = 4'(entries.size());
      pending_results = {pending_results, want};
    endfunction

    function void check_result(queue_result_t got);
      queue_result_t want;
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result: status=%0d id=%h burst=%h prio=%h arr=%h occ=%0d",
                   got.status, got.rec.id, got.rec.burst, got.rec.prio,
                   got.rec.arrival, got.occupancy);
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status || got.rec !== want.rec ||
          got.occupancy !== want.occupancy) begin
        error_count++;
        if (error_count <= 10) begin
          $display("mismatch expected: status=%0d id=%h burst=%h prio=%h arr=%h occ=%0d",
                   want.status, want.rec.id, want.rec.burst, want.rec.prio,
                   want.rec.arrival, want.occupancy);
          $display("         actual:   status=%0d id=%h burst=%h prio=%h arr=%h occ=%0d",
                   got.status, got.rec.id, got.rec.burst, got.rec.prio,
                   got.rec.arrival, got.occupancy);
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        sorted_mode_we_i;
  logic        sorted_mode_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  op_i;
  logic [15:0] in_id_i;
  logic [15:0] in_burst_i;
  logic [7:0]  in_priority_i;
  logic [15:0] in_arrival_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  status_o;
  logic [15:0] out_id_o;
  logic [15:0] out_burst_o;
  logic [7:0]  out_priority_o;
  logic [15:0] out_arrival_o;
  logic [3:0]  occupancy_o;

  ready_queue_model queue_model = new();
  bit               idle_on = 1'b1;
  int unsigned      cycle_count = 0;

  sorted_ready_queue dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .sorted_mode_we_i (sorted_mode_we_i),
    .sorted_mode_i    (sorted_mode_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .op_i             (op_i),
    .in_id_i          (in_id_i),
    .in_burst_i       (in_burst_i),
    .in_priority_i    (in_priority_i),
    .in_arrival_i     (in_arrival_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .out_id_o         (out_id_o),
    .out_burst_o      (out_burst_o),
    .out_priority_o   (out_priority_o),
    .out_arrival_o    (out_arrival_o),
    .occupancy_o      (occupancy_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Transactions on both channels, sampled with pre-edge values.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        queue_model.note_transaction(op_i, '{in_id_i, in_burst_i, in_priority_i,
                                             in_arrival_i});
      if (out_valid_o && out_ready_i)
        queue_model.check_result('{status_o, '{out_id_o, out_burst_o,
                                                out_priority_o, out_arrival_o},
                                   occupancy_o});
    end
  end

  // Result side: random stall bursts while idling is on.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 6) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  function automatic proc_rec_t random_rec(bit narrow_prio);
    proc_rec_t rec;
    rec.id      = 16'($urandom);
    rec.burst   = 16'($urandom);
    rec.prio    = narrow_prio ? 8'($urandom_range(0, 3)) : 8'($urandom);
    rec.arrival = 16'($urandom);
    return rec;
  endfunction

  task automatic send_item(input logic [1:0] op, input proc_rec_t rec);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= op;
    in_id_i       <= rec.id;
    in_burst_i    <= rec.burst;
    in_priority_i <= rec.prio;
    in_arrival_i  <= rec.arrival;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stop sending and wait until every outstanding result has been taken.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (queue_model.pending_results.size() != 0);
  endtask

  task automatic write_mode(input bit mode);
    drain_results();
    sorted_mode_we_i <= 1'b1;
    sorted_mode_i    <= mode;
    @(posedge clk_i);
    queue_model.sorted = mode;
    sorted_mode_we_i <= 1'b0;
  endtask

  initial begin
    int unsigned push_pct;
    int unsigned pick;
    bit          narrow;

    rst_ni           = 1'b0;
    sorted_mode_we_i = 1'b0;
    sorted_mode_i    = 1'b0;
    in_valid_i       = 1'b0;
    op_i             = OP_PUSH;
    in_id_i          = '0;
    in_burst_i       = '0;
    in_priority_i    = '0;
    in_arrival_i     = '0;
    out_ready_i      = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty pops, extremes, full queue, sorted insert into FIFO order
    write_mode(1'b0);
    send_item(OP_POP_TAIL, '0);
    send_item(OP_POP_HEAD, '0);
    send_item(OpIgnored, '1);
    send_item(OP_PUSH, '1);
    send_item(OP_PUSH, '0);
    for (int i = 0; i < SrqDepth - 2; i++)
      send_item(OP_PUSH, '{16'(i + 1), 16'(100 * i), 8'(200 - 20 * i), 16'(i)});
    send_item(OP_PUSH, '1);
    send_item(OpIgnored, '1);
    send_item(OP_POP_HEAD, '0);
    send_item(OP_POP_TAIL, '0);
    write_mode(1'b1);
    send_item(OP_PUSH, '{16'hA001, 16'h0001, 8'd100, 16'h0010});
    send_item(OP_PUSH, '{16'hA002, 16'h0002, 8'd0, 16'h0020});
    send_item(OP_PUSH, '{16'hA003, 16'h0003, 8'd255, 16'h0030});
    send_item(OP_POP_HEAD, '0);
    send_item(OP_POP_HEAD, '0);
    send_item(OP_POP_TAIL, '0);
    send_item(OP_PUSH, '{16'hB001, 16'h0004, 8'd100, 16'h0040});
    send_item(OP_PUSH, '{16'hB002, 16'h0005, 8'd100, 16'h0050});
    send_item(OP_PUSH, '{16'hB003, 16'hFFFF, 8'd255, 16'hFFFF});

    // Random phases; the last one runs without idling on either side.
    for (int phase = 0; phase < 8; phase++) begin
      write_mode(phase == 0 ? 1'b0 : phase == 1 ? 1'b1 : 1'($urandom_range(0, 1)));
      idle_on  = (phase < 7);
      push_pct = $urandom_range(30, 70);
      narrow   = 1'($urandom_range(0, 1));
      for (int n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(0, 199) == 0) drain_results();
        pick = $urandom_range(0, 99);
        if (pick < 3) send_item(OpIgnored, random_rec(narrow));
        else if (pick < 3 + push_pct) send_item(OP_PUSH, random_rec(narrow));
        else if ($urandom_range(0, 1) == 0) send_item(OP_POP_TAIL, random_rec(narrow));
        else send_item(OP_POP_HEAD, random_rec(narrow));
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (queue_model.error_count == 0 && queue_model.pending_results.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
